>>> rtl/tagf_pkg.sv
// ----------------------------------------------------------------------------
// tagf_pkg
// Shared widths, payload structs and helpers for the triangle area gradient
// force pipeline.
// ----------------------------------------------------------------------------
package tagf_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NRM_BITS    = 30;
    localparam int COEFF_WIDTH = 32;

    localparam int EW       = COORD_WIDTH + 1;       // edge component
    localparam int PW       = 2 * EW;                // edge product
    localparam int AW       = PW + 1;                // area vector component
    localparam int BLW      = $clog2(AW + 1);        // bit length / shift
    localparam int MW       = NRM_BITS;              // reduced magnitude
    localparam int QW       = 2 * MW + 2;            // squared length
    localparam int SRW      = QW + 1;                // square root working regs
    localparam int SQ_STEPS = QW / 2;
    localparam int RW       = MW + 1;                // root
    localparam int DW       = 2 * MW + 1;            // dividend
    localparam int QTW      = MW + 1;                // quotient
    localparam int NW       = MW + 2;                // signed normal
    localparam int XW       = EW + NW;               // edge times normal
    localparam int TW       = XW + 1 - NRM_BITS;     // rounded cross product
    localparam int CPW      = COEFF_WIDTH + TW;      // coefficient product
    localparam int PRW      = CPW - FRAC_BITS;       // rounded force
    localparam int P0W      = PRW + 2;               // force sum and negation

    typedef logic [2:0][EW-1:0] evec_t;

    typedef struct packed {
        evec_t      e1;
        evec_t      e2;
        logic [2:0] neg;
        logic       zero;
    } geo_t;

    typedef struct packed {
        geo_t               geo;
        logic [2:0][MW-1:0] m;
        logic [QW-1:0]      q;
    } area_t;

    typedef struct packed {
        geo_t               geo;
        logic [2:0][MW-1:0] m;
        logic [RW-1:0]      r;
    } root_t;

    typedef struct packed {
        geo_t               geo;
        logic [2:0][NW-1:0] n;
    } nrm_t;

    function automatic logic [COORD_WIDTH-1:0] sat_force(input logic [P0W-1:0] x);
        logic signed [P0W-1:0] hi;
        logic signed [P0W-1:0] lo;
        hi = {{(P0W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
        lo = {{(P0W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
        if ($signed(x) > hi) begin
            return hi[COORD_WIDTH-1:0];
        end else if ($signed(x) < lo) begin
            return lo[COORD_WIDTH-1:0];
        end
        return x[COORD_WIDTH-1:0];
    endfunction

endpackage

>>> rtl/tagf_area.sv
// ----------------------------------------------------------------------------
// tagf_area
// Edges, area vector, common normalising shift and squared length.
// ----------------------------------------------------------------------------
module tagf_area import tagf_pkg::*; (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [8:0][COORD_WIDTH-1:0]       vert,
    output logic                              out_valid,
    output area_t                             out_data
);

    logic [7:0] vld_reg;

    evec_t              e1_s1_reg, e2_s1_reg, e1_s2_reg, e2_s2_reg, e1_s3_reg, e2_s3_reg;
    logic [5:0][PW-1:0] pr_reg;
    logic [2:0][AW-1:0] a_reg;
    logic [2:0][AW-1:0] mag_reg, mag5_reg;
    geo_t               geo4_reg, geo5_reg, geo6_reg, geo7_reg, geo8_reg;
    logic [BLW-1:0]     sh_reg;
    logic [2:0][MW-1:0] m6_reg, m7_reg, m8_reg;
    logic [2:0][2*MW-1:0] sq_reg;
    logic [QW-1:0]      q_reg;

    evec_t              e1_next, e2_next;
    logic [AW-1:0]      orv;
    logic [BLW-1:0]     bl;
    logic [BLW-1:0]     sh_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e1_next[i] = EW'($signed(vert[3+i])) - EW'($signed(vert[i]));
            e2_next[i] = EW'($signed(vert[6+i])) - EW'($signed(vert[i]));
        end
    end

    // bit length of the largest magnitude
    always_comb begin
        orv = mag_reg[0] | mag_reg[1] | mag_reg[2];
        bl  = '0;
        for (int i = 0; i < AW; i++) begin
            if (orv[i]) begin
                bl = BLW'(i + 1);
            end
        end
        sh_next = (bl > BLW'(NRM_BITS)) ? bl - BLW'(NRM_BITS) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_s1_reg <= e1_next;
            e2_s1_reg <= e2_next;

            pr_reg[0] <= PW'($signed(e1_s1_reg[1])) * PW'($signed(e2_s1_reg[2]));
            pr_reg[1] <= PW'($signed(e1_s1_reg[2])) * PW'($signed(e2_s1_reg[1]));
            pr_reg[2] <= PW'($signed(e1_s1_reg[2])) * PW'($signed(e2_s1_reg[0]));
            pr_reg[3] <= PW'($signed(e1_s1_reg[0])) * PW'($signed(e2_s1_reg[2]));
            pr_reg[4] <= PW'($signed(e1_s1_reg[0])) * PW'($signed(e2_s1_reg[1]));
            pr_reg[5] <= PW'($signed(e1_s1_reg[1])) * PW'($signed(e2_s1_reg[0]));
            e1_s2_reg <= e1_s1_reg;
            e2_s2_reg <= e2_s1_reg;

            for (int i = 0; i < 3; i++) begin
                a_reg[i] <= AW'($signed(pr_reg[2*i])) - AW'($signed(pr_reg[2*i+1]));
            end
            e1_s3_reg <= e1_s2_reg;
            e2_s3_reg <= e2_s2_reg;

            for (int i = 0; i < 3; i++) begin
                geo4_reg.neg[i] <= a_reg[i][AW-1];
                mag_reg[i]      <= a_reg[i][AW-1] ? (~a_reg[i] + AW'(1)) : a_reg[i];
            end
            geo4_reg.zero <= ~|{a_reg[0], a_reg[1], a_reg[2]};
            geo4_reg.e1   <= e1_s3_reg;
            geo4_reg.e2   <= e2_s3_reg;

            sh_reg   <= sh_next;
            mag5_reg <= mag_reg;
            geo5_reg <= geo4_reg;

            for (int i = 0; i < 3; i++) begin
                m6_reg[i] <= MW'(mag5_reg[i] >> sh_reg);
            end
            geo6_reg <= geo5_reg;

            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= (2*MW)'(m6_reg[i]) * (2*MW)'(m6_reg[i]);
            end
            m7_reg   <= m6_reg;
            geo7_reg <= geo6_reg;

            q_reg    <= QW'(sq_reg[0]) + QW'(sq_reg[1]) + QW'(sq_reg[2]);
            m8_reg   <= m7_reg;
            geo8_reg <= geo7_reg;
        end
    end

    assign out_valid     = vld_reg[7];
    assign out_data.geo  = geo8_reg;
    assign out_data.m    = m8_reg;
    assign out_data.q    = q_reg;

endmodule

>>> rtl/tagf_isqrt.sv
// ----------------------------------------------------------------------------
// tagf_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module tagf_isqrt import tagf_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   in_valid,
    input  area_t  in_data,
    output logic   out_valid,
    output root_t  out_data
);

    logic [SQ_STEPS:0]          vld_reg;
    logic [SRW-1:0]             q_reg [SQ_STEPS+1];
    logic [SRW-1:0]             r_reg [SQ_STEPS+1];
    geo_t                       geo_reg [SQ_STEPS+1];
    logic [2:0][MW-1:0]         m_reg [SQ_STEPS+1];

    always_comb begin
        vld_reg[0] = in_valid;
        q_reg[0]   = SRW'(in_data.q);
        r_reg[0]   = '0;
        geo_reg[0] = in_data.geo;
        m_reg[0]   = in_data.m;
    end

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
        localparam logic [SRW-1:0] BIT = SRW'(1) << (2 * (SQ_STEPS - 1 - j));
        logic [SRW-1:0] trial;
        assign trial = r_reg[j] + BIT;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j+1] <= 1'b0;
            end else if (en) begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (q_reg[j] >= trial) begin
                    q_reg[j+1] <= q_reg[j] - trial;
                    r_reg[j+1] <= (r_reg[j] >> 1) + BIT;
                end else begin
                    q_reg[j+1] <= q_reg[j];
                    r_reg[j+1] <= r_reg[j] >> 1;
                end
                geo_reg[j+1] <= geo_reg[j];
                m_reg[j+1]   <= m_reg[j];
            end
        end
    end

    assign out_valid    = vld_reg[SQ_STEPS];
    assign out_data.geo = geo_reg[SQ_STEPS];
    assign out_data.m   = m_reg[SQ_STEPS];
    assign out_data.r   = r_reg[SQ_STEPS][RW-1:0];

endmodule

>>> rtl/tagf_div.sv
// ----------------------------------------------------------------------------
// tagf_div
// Three-lane pipelined restoring divider giving the rounded unit normal.
// ----------------------------------------------------------------------------
module tagf_div import tagf_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   in_valid,
    input  root_t  in_data,
    output logic   out_valid,
    output nrm_t   out_data
);

    logic [QTW+1:0]             vld_reg;
    logic [2:0][DW-1:0]         rem_reg [QTW+1];
    logic [2:0][QTW-1:0]        quo_reg [QTW+1];
    logic [RW-1:0]              r_reg   [QTW+1];
    geo_t                       geo_reg [QTW+1];
    geo_t                       geo_out_reg;
    logic [2:0][NW-1:0]         n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QTW:0], in_valid};
        end
    end

    // dividend with half the divisor added for rounding
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                rem_reg[0][i] <= (DW'(in_data.m[i]) << NRM_BITS) + DW'(in_data.r >> 1);
            end
            quo_reg[0] <= '0;
            r_reg[0]   <= in_data.r;
            geo_reg[0] <= in_data.geo;
        end
    end

    for (genvar j = 0; j < QTW; j++) begin : g_step
        localparam int SH = QTW - 1 - j;
        logic [DW-1:0] dv;
        assign dv = DW'(r_reg[j]) << SH;

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    if (rem_reg[j][i] >= dv) begin
                        rem_reg[j+1][i]     <= rem_reg[j][i] - dv;
                        quo_reg[j+1][i]     <= quo_reg[j][i] | (QTW'(1) << SH);
                    end else begin
                        rem_reg[j+1][i]     <= rem_reg[j][i];
                        quo_reg[j+1][i]     <= quo_reg[j][i];
                    end
                end
                r_reg[j+1]   <= r_reg[j];
                geo_reg[j+1] <= geo_reg[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                n_reg[i] <= geo_reg[QTW].neg[i] ? (NW'(0) - NW'(quo_reg[QTW][i]))
                                                : NW'(quo_reg[QTW][i]);
            end
            geo_out_reg <= geo_reg[QTW];
        end
    end

    assign out_valid    = vld_reg[QTW+1];
    assign out_data.geo = geo_out_reg;
    assign out_data.n   = n_reg;

endmodule

>>> rtl/tagf_force.sv
// ----------------------------------------------------------------------------
// tagf_force
// Edge cross normal, coefficient scaling, vertex 0 sum and saturation.
// ----------------------------------------------------------------------------
module tagf_force import tagf_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  nrm_t                        in_data,
    input  logic [COEFF_WIDTH-1:0]      coeff,
    output logic                        out_valid,
    output logic [8:0][COORD_WIDTH-1:0] force_out,
    output logic                        degenerate
);

    logic [4:0]            vld_reg;
    logic [11:0][XW-1:0]   xp_reg;
    logic [5:0][TW-1:0]    tu_reg;
    logic [5:0][CPW-1:0]   cp_reg;
    logic [5:0][PRW-1:0]   fr_reg;
    logic [3:0]            zero_reg;
    logic [8:0][COORD_WIDTH-1:0] f_reg;
    logic                  deg_reg;

    logic [2:0][EW-1:0]    e1, e2;
    logic [2:0][NW-1:0]    n;
    logic [5:0][TW-1:0]    tu_next;
    logic [5:0][PRW-1:0]   fr_next;
    logic [XW:0]           dif;
    logic [CPW-1:0]        cr;

    assign e1 = in_data.geo.e1;
    assign e2 = in_data.geo.e2;
    assign n  = in_data.n;

    // lanes 0..2 are e1 x n (vertex 2), lanes 3..5 are n x e2 (vertex 1)
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            dif        = (XW+1)'($signed(xp_reg[2*i])) - (XW+1)'($signed(xp_reg[2*i+1]));
            dif        = dif + ((XW+1)'(1) << (NRM_BITS - 1));
            tu_next[i] = dif[XW:NRM_BITS];
        end
        for (int i = 0; i < 6; i++) begin
            cr         = cp_reg[i] + (CPW'(1) << (FRAC_BITS - 1));
            fr_next[i] = cr[CPW-1:FRAC_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xp_reg[0]  <= XW'($signed(e1[1])) * XW'($signed(n[2]));
            xp_reg[1]  <= XW'($signed(e1[2])) * XW'($signed(n[1]));
            xp_reg[2]  <= XW'($signed(e1[2])) * XW'($signed(n[0]));
            xp_reg[3]  <= XW'($signed(e1[0])) * XW'($signed(n[2]));
            xp_reg[4]  <= XW'($signed(e1[0])) * XW'($signed(n[1]));
            xp_reg[5]  <= XW'($signed(e1[1])) * XW'($signed(n[0]));
            xp_reg[6]  <= XW'($signed(n[1])) * XW'($signed(e2[2]));
            xp_reg[7]  <= XW'($signed(n[2])) * XW'($signed(e2[1]));
            xp_reg[8]  <= XW'($signed(n[2])) * XW'($signed(e2[0]));
            xp_reg[9]  <= XW'($signed(n[0])) * XW'($signed(e2[2]));
            xp_reg[10] <= XW'($signed(n[0])) * XW'($signed(e2[1]));
            xp_reg[11] <= XW'($signed(n[1])) * XW'($signed(e2[0]));
            zero_reg[0] <= in_data.geo.zero;

            tu_reg      <= tu_next;
            zero_reg[1] <= zero_reg[0];

            for (int i = 0; i < 6; i++) begin
                cp_reg[i] <= CPW'($signed(coeff)) * CPW'($signed(tu_reg[i]));
            end
            zero_reg[2] <= zero_reg[1];

            fr_reg      <= fr_next;
            zero_reg[3] <= zero_reg[2];

            for (int i = 0; i < 3; i++) begin
                if (zero_reg[3]) begin
                    f_reg[i]   <= '0;
                    f_reg[3+i] <= '0;
                    f_reg[6+i] <= '0;
                end else begin
                    f_reg[i]   <= sat_force(P0W'(0) - (P0W'($signed(fr_reg[3+i]))
                                                     + P0W'($signed(fr_reg[i]))));
                    f_reg[3+i] <= sat_force(P0W'($signed(fr_reg[3+i])));
                    f_reg[6+i] <= sat_force(P0W'($signed(fr_reg[i])));
                end
            end
            deg_reg <= zero_reg[3];
        end
    end

    assign out_valid  = vld_reg[4];
    assign force_out  = f_reg;
    assign degenerate = deg_reg;

endmodule

>>> rtl/triangle_area_gradient_force_top.sv
// throughput: one item per cycle; the whole pipeline holds while a result waits
// the square root (31 stages) and the normal divider (33 stages) set the depth
// reset: synchronous active-low aresetn empties the pipeline and clears the
// tension coefficient to zero
// ----------------------------------------------------------------------------
// triangle_area_gradient_force_top
// Surface tension force on the three vertices of one triangle per item.
// ----------------------------------------------------------------------------
module triangle_area_gradient_force_top import tagf_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [COEFF_WIDTH-1:0] cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [COORD_WIDTH-1:0] s_v0_x,
    input  logic [COORD_WIDTH-1:0] s_v0_y,
    input  logic [COORD_WIDTH-1:0] s_v0_z,
    input  logic [COORD_WIDTH-1:0] s_v1_x,
    input  logic [COORD_WIDTH-1:0] s_v1_y,
    input  logic [COORD_WIDTH-1:0] s_v1_z,
    input  logic [COORD_WIDTH-1:0] s_v2_x,
    input  logic [COORD_WIDTH-1:0] s_v2_y,
    input  logic [COORD_WIDTH-1:0] s_v2_z,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COORD_WIDTH-1:0] m_f0_x,
    output logic [COORD_WIDTH-1:0] m_f0_y,
    output logic [COORD_WIDTH-1:0] m_f0_z,
    output logic [COORD_WIDTH-1:0] m_f1_x,
    output logic [COORD_WIDTH-1:0] m_f1_y,
    output logic [COORD_WIDTH-1:0] m_f1_z,
    output logic [COORD_WIDTH-1:0] m_f2_x,
    output logic [COORD_WIDTH-1:0] m_f2_y,
    output logic [COORD_WIDTH-1:0] m_f2_z,
    output logic                   m_degenerate
);

    logic [COEFF_WIDTH-1:0]      coeff_reg;
    logic                        adv;
    logic [8:0][COORD_WIDTH-1:0] vert;
    logic [8:0][COORD_WIDTH-1:0] fo;
    logic                        area_vld, root_vld, nrm_vld;
    area_t                       area_d;
    root_t                       root_d;
    nrm_t                        nrm_d;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg <= '0;
        end else if (cfg_we) begin
            coeff_reg <= cfg_wdata;
        end
    end

    // every stage moves together unless a finished item is still held
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    assign vert = {s_v2_z, s_v2_y, s_v2_x, s_v1_z, s_v1_y, s_v1_x, s_v0_z, s_v0_y, s_v0_x};

    tagf_area u_area (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_valid),
        .vert      (vert),
        .out_valid (area_vld),
        .out_data  (area_d)
    );

    tagf_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (area_vld),
        .in_data   (area_d),
        .out_valid (root_vld),
        .out_data  (root_d)
    );

    tagf_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (root_vld),
        .in_data   (root_d),
        .out_valid (nrm_vld),
        .out_data  (nrm_d)
    );

    tagf_force u_force (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_valid   (nrm_vld),
        .in_data    (nrm_d),
        .coeff      (coeff_reg),
        .out_valid  (m_valid),
        .force_out  (fo),
        .degenerate (m_degenerate)
    );

    assign m_f0_x = fo[0];
    assign m_f0_y = fo[1];
    assign m_f0_z = fo[2];
    assign m_f1_x = fo[3];
    assign m_f1_y = fo[4];
    assign m_f1_z = fo[5];
    assign m_f2_x = fo[6];
    assign m_f2_y = fo[7];
    assign m_f2_z = fo[8];

endmodule
